// ----- design/bap_pkg.sv -----
package bap_pkg;

  localparam int MAX_WIDTH_DEF     = 640;
  localparam int MAX_HEIGHT_DEF    = 480;
  localparam int DEFAULT_BLOCK_DEF = 8;

  localparam int CH_W       = 8;
  localparam int CH_MAX     = 255;
  localparam int FW_W       = 10;
  localparam int FH_W       = 9;
  localparam int BS_W       = 8;
  localparam int PP_W       = 19;
  localparam int SUM_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int IDX_W      = 21;
  localparam int DIV_DW     = 24;
  localparam int DIV_VW     = 16;
  localparam int QDEPTH     = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_PULL = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BLOCK  = 2'd2,
    CFG_OFFSET = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef struct packed {
    logic pop;
    logic hold;
  } front_ctrl_t;

endpackage

// ----- design/bap_ram.sv -----
module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bap_div.sv -----
module bap_div import bap_pkg::*; #(
  parameter int DW = DIV_DW,
  parameter int VW = DIV_VW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic          ge;
  logic [VW:0]   diff;

  assign trial = {remainder, quotient[DW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CW'(DW);
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (busy) begin
        remainder <= ge ? diff[VW-1:0] : trial[VW-1:0];
        quotient  <= {quotient[DW-2:0], ge};
        cnt       <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/bap_front.sv -----
module bap_front import bap_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            cmd,
  input  logic [CH_W-1:0] red_in,
  input  logic [CH_W-1:0] green_in,
  input  logic [CH_W-1:0] blue_in,
  input  front_ctrl_t     ctrl,
  output queue_out_t      head
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         entries [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign busy       = (count == CW'(QDEPTH)) || ctrl.hold;
  assign push       = start && !busy;
  assign pop        = ctrl.pop && head.valid;
  assign head.valid = count != '0;
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{cmd: cmd_t'(cmd), red: red_in, green: green_in, blue: blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// ----- design/bap_back.sv -----
module bap_back import bap_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int DEFAULT_BLOCK = DEFAULT_BLOCK_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  queue_out_t            head,
  output front_ctrl_t           ctrl,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  idle,
  output logic                  done,
  output logic [CH_W-1:0]       red_out,
  output logic [CH_W-1:0]       green_out,
  output logic [CH_W-1:0]       blue_out,
  output logic                  ready_res,
  output logic                  last_pixel
);

  localparam int SAW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int TDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int NS     = 27;
  localparam int XW     = 20;

  typedef enum logic [NS-1:0] {
    S_IDLE    = NS'(1) << 0,
    S_CLR     = NS'(1) << 1,
    S_LD_START = NS'(1) << 2,
    S_LD_BC   = NS'(1) << 3,
    S_LD_RD   = NS'(1) << 4,
    S_LD_ACC  = NS'(1) << 5,
    S_LD_MOD  = NS'(1) << 6,
    S_CS_ROW  = NS'(1) << 7,
    S_CS_NC   = NS'(1) << 8,
    S_CS_BASE = NS'(1) << 9,
    S_SW_RD   = NS'(1) << 10,
    S_SW_CNT  = NS'(1) << 11,
    S_SW_DRS  = NS'(1) << 12,
    S_SW_DR   = NS'(1) << 13,
    S_SW_DG   = NS'(1) << 14,
    S_SW_DB   = NS'(1) << 15,
    S_SW_WR   = NS'(1) << 16,
    S_FIN     = NS'(1) << 17,
    S_PL_CHK  = NS'(1) << 18,
    S_PL_Y    = NS'(1) << 19,
    S_PL_YB   = NS'(1) << 20,
    S_PL_XB   = NS'(1) << 21,
    S_PL_NC   = NS'(1) << 22,
    S_PL_MUL  = NS'(1) << 23,
    S_PL_IDX  = NS'(1) << 24,
    S_PL_RD   = NS'(1) << 25,
    S_PL_OUT  = NS'(1) << 26
  } state_t;

  function automatic logic [CH_W-1:0] sat_avg(input logic [DIV_DW-1:0] q,
                                               input logic [CH_W-1:0] off);
    logic [DIV_DW:0] v;
    v = {1'b0, q} + (DIV_DW + 1)'(off);
    return (v > (DIV_DW + 1)'(CH_MAX)) ? CH_W'(CH_MAX) : v[CH_W-1:0];
  endfunction

  state_t state;

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [BS_W-1:0] block_size;
  logic [CH_W-1:0] brightness_offset;

  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;
  logic [BS_W-1:0] b_eff;

  item_t           item;
  logic [FW_W-1:0] load_column;
  logic [FH_W-1:0] load_row;
  logic            frame_complete;
  logic [PP_W-1:0] pull_position;
  logic            clr_ret;

  logic [SAW-1:0]   sw_idx;
  logic [FW_W-1:0]  bc;
  logic [FH_W-1:0]  sidx;
  logic [BS_W-1:0]  rows;
  logic [FW_W:0]    ncols;
  logic [IDX_W-1:0] base;
  logic [XW-1:0]    x0;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [DIV_VW-1:0] count;
  logic [CH_W-1:0]  av_r;
  logic [CH_W-1:0]  av_g;
  logic [PP_W-1:0]  total;
  logic [FW_W-1:0]  pos_x;
  logic [FH_W-1:0]  yb;
  logic [FW_W-1:0]  xb;
  logic [IDX_W-1:0] prod;
  logic [IDX_W-1:0] idx;

  logic              div_start;
  logic [DIV_DW-1:0] div_a;
  logic [DIV_VW-1:0] div_b;
  logic              div_busy;
  logic              div_done;
  logic [DIV_DW-1:0] div_q;
  logic [DIV_VW-1:0] div_r;

  logic                 sum_we;
  logic [SAW-1:0]       sum_waddr;
  logic [3*SUM_W-1:0]   sum_wdata;
  logic [SAW-1:0]       sum_raddr;
  logic [3*SUM_W-1:0]   sum_rdata;
  logic                 tab_we;
  logic [TAW-1:0]       tab_waddr;
  logic [3*CH_W-1:0]    tab_wdata;
  logic [TAW-1:0]       tab_raddr;
  logic [3*CH_W-1:0]    tab_rdata;

  logic [IDX_W-1:0] tw_idx;
  logic             sw_in_range;
  logic             sw_last;
  logic [FH_W:0]    row_inc;
  logic             row_last;
  logic [FW_W:0]    ncols_num;
  logic [XW-1:0]    col_left;
  logic [BS_W-1:0]  bw;
  logic [FW_W-1:0]  col_e;

  assign w_eff = (frame_width == '0) ? FW_W'(1) :
                 (32'(frame_width) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : frame_width;
  assign h_eff = (frame_height == '0) ? FH_W'(1) :
                 (32'(frame_height) > MAX_HEIGHT) ? FH_W'(MAX_HEIGHT) : frame_height;
  assign b_eff = (block_size == '0) ? BS_W'(DEFAULT_BLOCK) : block_size;

  assign row_inc     = {1'b0, load_row} + 1'b1;
  assign row_last    = row_inc >= {1'b0, h_eff};
  assign ncols_num   = {1'b0, w_eff} + (FW_W + 1)'(b_eff) - 1'b1;
  assign sw_in_range = IDX_W'(sw_idx) < IDX_W'(ncols);
  assign sw_last     = sw_idx == SAW'(MAX_WIDTH - 1);
  assign tw_idx      = base + IDX_W'(sw_idx);
  assign col_left    = XW'(w_eff) - x0;
  assign bw          = (col_left < XW'(b_eff)) ? col_left[BS_W-1:0] : b_eff;
  assign col_e       = (load_column >= w_eff) ? '0 : load_column;

  assign ctrl.pop  = (state == S_IDLE) && head.valid;
  assign ctrl.hold = (state == S_CLR) && !clr_ret;
  assign idle      = (state == S_IDLE) && !head.valid;

  always_comb begin
    sum_raddr = (state == S_SW_RD) ? sw_idx : SAW'(bc);
    sum_we    = 1'b0;
    sum_waddr = sw_idx;
    sum_wdata = '0;
    unique case (state)
      S_CLR, S_SW_WR: begin
        sum_we = 1'b1;
      end
      S_SW_RD: begin
        sum_we = !sw_in_range;
      end
      S_LD_ACC: begin
        sum_we    = 1'b1;
        sum_waddr = SAW'(bc);
        sum_wdata = {sum_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(item.red),
                     sum_rdata[2*SUM_W-1:SUM_W] + SUM_W'(item.green),
                     sum_rdata[SUM_W-1:0] + SUM_W'(item.blue)};
      end
      default: begin
      end
    endcase
  end

  assign tab_we    = (state == S_SW_WR) && (32'(tw_idx) < TDEPTH);
  assign tab_waddr = TAW'(tw_idx);
  assign tab_wdata = {av_r, av_g, sat_avg(div_q, brightness_offset)};
  assign tab_raddr = TAW'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= FW_W'(MAX_WIDTH_DEF);
      frame_height      <= FH_W'(MAX_HEIGHT_DEF);
      block_size        <= BS_W'(DEFAULT_BLOCK_DEF);
      brightness_offset <= '0;
    end else if (cfg_valid && idle) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH:  frame_width       <= cfg_data[FW_W-1:0];
        CFG_HEIGHT: frame_height      <= cfg_data[FH_W-1:0];
        CFG_BLOCK:  block_size        <= cfg_data[BS_W-1:0];
        CFG_OFFSET: brightness_offset <= cfg_data[CH_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      clr_ret        <= 1'b0;
      sw_idx         <= '0;
      load_column    <= '0;
      load_row       <= '0;
      frame_complete <= 1'b0;
      pull_position  <= '0;
      div_start      <= 1'b0;
      done           <= 1'b0;
    end else begin
      div_start <= 1'b0;
      done      <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            item <= head.item;
            if (head.item.cmd == CMD_LOAD) begin
              if (frame_complete) begin
                frame_complete <= 1'b0;
                pull_position  <= '0;
              end
              if (load_row >= h_eff) begin
                load_row    <= '0;
                load_column <= '0;
                sw_idx      <= '0;
                clr_ret     <= 1'b1;
                state       <= S_CLR;
              end else begin
                state <= S_LD_START;
              end
            end else if (!frame_complete) begin
              done       <= 1'b1;
              red_out    <= '0;
              green_out  <= '0;
              blue_out   <= '0;
              ready_res  <= 1'b0;
              last_pixel <= 1'b0;
            end else begin
              total <= PP_W'(w_eff * h_eff);
              state <= S_PL_CHK;
            end
          end
        end
        S_CLR: begin
          if (sw_last) begin
            sw_idx <= '0;
            state  <= clr_ret ? S_LD_START : S_IDLE;
          end else begin
            sw_idx <= sw_idx + 1'b1;
          end
        end
        S_LD_START: begin
          load_column <= col_e;
          div_a       <= DIV_DW'(col_e);
          div_b       <= DIV_VW'(b_eff);
          div_start   <= 1'b1;
          state       <= S_LD_BC;
        end
        S_LD_BC: begin
          if (div_done) begin
            bc    <= div_q[FW_W-1:0];
            state <= S_LD_RD;
          end
        end
        S_LD_RD: begin
          state <= S_LD_ACC;
        end
        S_LD_ACC: begin
          if ((FW_W + 1)'(load_column) + 1'b1 >= (FW_W + 1)'(w_eff)) begin
            load_column <= '0;
            div_a       <= DIV_DW'(row_inc);
            div_b       <= DIV_VW'(b_eff);
            div_start   <= 1'b1;
            state       <= S_LD_MOD;
          end else begin
            load_column <= load_column + 1'b1;
            state       <= S_IDLE;
          end
        end
        S_LD_MOD: begin
          if (div_done) begin
            if (div_r == '0 || row_last) begin
              div_a     <= DIV_DW'(load_row);
              div_b     <= DIV_VW'(b_eff);
              div_start <= 1'b1;
              state     <= S_CS_ROW;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_CS_ROW: begin
          if (div_done) begin
            sidx      <= div_q[FH_W-1:0];
            rows      <= div_r[BS_W-1:0] + 1'b1;
            div_a     <= DIV_DW'(ncols_num);
            div_b     <= DIV_VW'(b_eff);
            div_start <= 1'b1;
            state     <= S_CS_NC;
          end
        end
        S_CS_NC: begin
          if (div_done) begin
            ncols <= div_q[FW_W:0];
            state <= S_CS_BASE;
          end
        end
        S_CS_BASE: begin
          base   <= IDX_W'(sidx * ncols);
          sw_idx <= '0;
          x0     <= '0;
          state  <= S_SW_RD;
        end
        S_SW_RD: begin
          if (sw_in_range) begin
            state <= S_SW_CNT;
          end else if (sw_last) begin
            state <= S_FIN;
          end else begin
            sw_idx <= sw_idx + 1'b1;
          end
        end
        S_SW_CNT: begin
          sum_r <= sum_rdata[3*SUM_W-1:2*SUM_W];
          sum_g <= sum_rdata[2*SUM_W-1:SUM_W];
          sum_b <= sum_rdata[SUM_W-1:0];
          count <= DIV_VW'(bw * rows);
          state <= S_SW_DRS;
        end
        S_SW_DRS: begin
          div_a     <= DIV_DW'(sum_r);
          div_b     <= count;
          div_start <= 1'b1;
          state     <= S_SW_DR;
        end
        S_SW_DR: begin
          if (div_done) begin
            av_r      <= sat_avg(div_q, brightness_offset);
            div_a     <= DIV_DW'(sum_g);
            div_start <= 1'b1;
            state     <= S_SW_DG;
          end
        end
        S_SW_DG: begin
          if (div_done) begin
            av_g      <= sat_avg(div_q, brightness_offset);
            div_a     <= DIV_DW'(sum_b);
            div_start <= 1'b1;
            state     <= S_SW_DB;
          end
        end
        S_SW_DB: begin
          if (div_done) begin
            state <= S_SW_WR;
          end
        end
        S_SW_WR: begin
          x0 <= x0 + XW'(b_eff);
          if (sw_last) begin
            state <= S_FIN;
          end else begin
            sw_idx <= sw_idx + 1'b1;
            state  <= S_SW_RD;
          end
        end
        S_FIN: begin
          if (row_last) begin
            load_row       <= '0;
            frame_complete <= 1'b1;
            pull_position  <= '0;
          end else begin
            load_row <= row_inc[FH_W-1:0];
          end
          state <= S_IDLE;
        end
        S_PL_CHK: begin
          if (pull_position >= total) begin
            done           <= 1'b1;
            red_out        <= '0;
            green_out      <= '0;
            blue_out       <= '0;
            ready_res      <= 1'b0;
            last_pixel     <= 1'b0;
            frame_complete <= 1'b0;
            pull_position  <= '0;
            state          <= S_IDLE;
          end else begin
            div_a     <= DIV_DW'(pull_position);
            div_b     <= DIV_VW'(w_eff);
            div_start <= 1'b1;
            state     <= S_PL_Y;
          end
        end
        S_PL_Y: begin
          if (div_done) begin
            pos_x     <= div_r[FW_W-1:0];
            div_a     <= div_q;
            div_b     <= DIV_VW'(b_eff);
            div_start <= 1'b1;
            state     <= S_PL_YB;
          end
        end
        S_PL_YB: begin
          if (div_done) begin
            yb        <= div_q[FH_W-1:0];
            div_a     <= DIV_DW'(pos_x);
            div_start <= 1'b1;
            state     <= S_PL_XB;
          end
        end
        S_PL_XB: begin
          if (div_done) begin
            xb        <= div_q[FW_W-1:0];
            div_a     <= DIV_DW'(ncols_num);
            div_start <= 1'b1;
            state     <= S_PL_NC;
          end
        end
        S_PL_NC: begin
          if (div_done) begin
            ncols <= div_q[FW_W:0];
            state <= S_PL_MUL;
          end
        end
        S_PL_MUL: begin
          prod  <= IDX_W'(yb * ncols);
          state <= S_PL_IDX;
        end
        S_PL_IDX: begin
          idx   <= prod + IDX_W'(xb);
          state <= S_PL_RD;
        end
        S_PL_RD: begin
          state <= S_PL_OUT;
        end
        S_PL_OUT: begin
          done      <= 1'b1;
          ready_res <= 1'b1;
          if (32'(idx) < TDEPTH) begin
            red_out   <= tab_rdata[3*CH_W-1:2*CH_W];
            green_out <= tab_rdata[2*CH_W-1:CH_W];
            blue_out  <= tab_rdata[CH_W-1:0];
          end else begin
            red_out   <= '0;
            green_out <= '0;
            blue_out  <= '0;
          end
          if ((PP_W + 1)'(pull_position) + 1'b1 >= (PP_W + 1)'(total)) begin
            last_pixel     <= 1'b1;
            frame_complete <= 1'b0;
            pull_position  <= '0;
          end else begin
            last_pixel    <= 1'b0;
            pull_position <= pull_position + 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bap_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  bap_ram #(
    .WIDTH(3 * SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_strip_ram (
    .clk  (clk),
    .we   (sum_we),
    .waddr(sum_waddr),
    .wdata(sum_wdata),
    .raddr(sum_raddr),
    .rdata(sum_rdata)
  );

  bap_ram #(
    .WIDTH(3 * CH_W),
    .DEPTH(TDEPTH)
  ) u_table_ram (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(tab_wdata),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  a_load_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_LD_ACC) |-> (load_column < w_eff))
    else $error("Load column ran past the frame width.");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ready_res) |->
      (red_out == '0 && green_out == '0 && blue_out == '0 && !last_pixel))
    else $error("A request answered as not ready carried nonzero fields.");

  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("The divider was started while still busy.");

  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_complete) |-> $past(state == S_FIN))
    else $error("Frame marked complete outside the end of a row.");

endmodule

// ----- design/block_average_pixelate.sv -----
// Channel   Signals                                   Handshake
// -------   ---------------------------------------   -----------------------------
// request   cmd, red_in, green_in, blue_in            start high while busy is low
// result    red_out, green_out, blue_out,             done strobe, one cycle
//           ready_res, last_pixel
// config    cfg_index, cfg_data                       cfg_valid and cfg_ready
//
// Requests are handled one at a time by a sequencer that shares one radix-2
// divider; each division holds the sequencer until the divider is done. A load
// adds the pixel to its block's strip sums; at the end of the last row of a strip
// each block column is averaged into the table and the strip sums are cleared.
// A pull divides to find the table entry and reads it, or answers not ready
// before the frame is complete. After reset the strip sums are cleared with busy
// high. A two-entry queue holds requests while the sequencer works; cfg_ready is
// low until the queue is empty and the sequencer is idle. Results cannot be stalled.
module block_average_pixelate import bap_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int DEFAULT_BLOCK = DEFAULT_BLOCK_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd,
  input  logic [CH_W-1:0]       red_in,
  input  logic [CH_W-1:0]       green_in,
  input  logic [CH_W-1:0]       blue_in,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [CH_W-1:0]       red_out,
  output logic [CH_W-1:0]       green_out,
  output logic [CH_W-1:0]       blue_out,
  output logic                  ready_res,
  output logic                  last_pixel
);

  front_ctrl_t ctrl;
  queue_out_t  head;

  bap_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .red_in  (red_in),
    .green_in(green_in),
    .blue_in (blue_in),
    .ctrl    (ctrl),
    .head    (head)
  );

  bap_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .DEFAULT_BLOCK(DEFAULT_BLOCK)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .ctrl      (ctrl),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .idle      (cfg_ready),
    .done      (done),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .ready_res (ready_res),
    .last_pixel(last_pixel)
  );

endmodule
